/* design/markup_to_html_stream_macros.svh */
// ============================================================================
// Markup-to-HTML stream assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ============================================================================
`ifndef MARKUP_TO_HTML_STREAM_MACROS_SVH
`define MARKUP_TO_HTML_STREAM_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define M2H_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define M2H_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/m2h_pkg.sv */
// ============================================================================
// Markup-to-HTML package
// Shared types, character codes, error codes and tag tables.
// ============================================================================
`timescale 1ns / 1ps

package m2h_pkg;

    // Style stack geometry.
    localparam int STACK_DEPTH = 4;
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Expansion buffer geometry: the longest expansion is a closing code tag
    // followed by a newline.
    localparam int MAX_RESULTS = 8;
    localparam int EXP_LEN_W   = $clog2(MAX_RESULTS + 1);
    localparam int EXP_DATA_W  = 8 * MAX_RESULTS;

    // Error codes carried on the result side.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ORDER    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // Input characters with a special meaning.
    localparam logic [7:0] CHAR_BOLD      = 8'h23; // '#'
    localparam logic [7:0] CHAR_ITALIC    = 8'h7E; // '~'
    localparam logic [7:0] CHAR_UNDERLINE = 8'h5F; // '_'
    localparam logic [7:0] CHAR_CODE      = 8'h60; // backtick
    localparam logic [7:0] CHAR_QUOTE     = 8'h22; // '"'
    localparam logic [7:0] CHAR_AMP       = 8'h26; // '&'
    localparam logic [7:0] CHAR_APOS      = 8'h27; // '\''
    localparam logic [7:0] CHAR_LT        = 8'h3C; // '<'
    localparam logic [7:0] CHAR_GT        = 8'h3E; // '>'
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    typedef enum logic [1:0] {
        STYLE_BOLD      = 2'd0,
        STYLE_ITALIC    = 2'd1,
        STYLE_UNDERLINE = 2'd2,
        STYLE_CODE      = 2'd3
    } style_t;

    // One expansion: bytes with the first one in the low byte, the number of
    // bytes, and the error code (nonzero only for a one-byte error result).
    typedef struct packed {
        logic [EXP_DATA_W-1:0] data;
        logic [EXP_LEN_W-1:0]  len;
        logic [1:0]            err;
    } exp_t;

    // Text of an open or close tag, first character in the low byte.
    function automatic logic [EXP_DATA_W-1:0] tag_text(style_t s, logic closing);
        logic [EXP_DATA_W-1:0] t;
        t = '0;
        unique case ({closing, s})
            {1'b0, STYLE_BOLD}:      t = EXP_DATA_W'({">", "b", "<"});
            {1'b0, STYLE_ITALIC}:    t = EXP_DATA_W'({">", "i", "<"});
            {1'b0, STYLE_UNDERLINE}: t = EXP_DATA_W'({">", "u", "<"});
            {1'b0, STYLE_CODE}:      t = EXP_DATA_W'({">", "e", "d", "o", "c", "<"});
            {1'b1, STYLE_BOLD}:      t = EXP_DATA_W'({">", "b", "/", "<"});
            {1'b1, STYLE_ITALIC}:    t = EXP_DATA_W'({">", "i", "/", "<"});
            {1'b1, STYLE_UNDERLINE}: t = EXP_DATA_W'({">", "u", "/", "<"});
            {1'b1, STYLE_CODE}:      t = EXP_DATA_W'({">", "e", "d", "o", "c", "/", "<"});
            default:                 t = '0;
        endcase
        return t;
    endfunction

    // Number of characters in the tag above.
    function automatic logic [EXP_LEN_W-1:0] tag_len(style_t s, logic closing);
        logic [EXP_LEN_W-1:0] n;
        if (s == STYLE_CODE)
            n = EXP_LEN_W'(6);
        else
            n = EXP_LEN_W'(3);
        if (closing)
            n = n + EXP_LEN_W'(1);
        return n;
    endfunction

endpackage

/* design/m2h_style_ctrl.sv */
// ============================================================================
// Markup-to-HTML style controller
// Holds the open-style stack and turns one registered byte into its expansion.
// ============================================================================
`timescale 1ns / 1ps
`include "markup_to_html_stream_macros.svh"

module m2h_style_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,       // the registered byte moves on this cycle
    input  logic [7:0]        char_in,
    input  logic              newline_after_tag,
    output m2h_pkg::exp_t     expansion
);

    localparam int CNT_W = m2h_pkg::STACK_CNT_W;
    localparam int IDX_W = m2h_pkg::STACK_IDX_W;
    localparam int LEN_W = m2h_pkg::EXP_LEN_W;
    localparam int DAT_W = m2h_pkg::EXP_DATA_W;

    // The stack entries are payload: an entry is only read after a push.
    m2h_pkg::style_t stack_mem [m2h_pkg::STACK_DEPTH];

    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [3:0]       flags_reg,  flags_next;
    logic             halted_reg, halted_next;

    logic             is_mark;
    m2h_pkg::style_t  mark_style;
    logic [CNT_W-1:0] cnt_m1;
    m2h_pkg::style_t  top_style;
    logic             push;
    logic             is_tag;
    logic             tag_close;
    logic [5:0]       nl_shift;

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign top_style = stack_mem[cnt_m1[IDX_W-1:0]];

    always_comb
    begin
        is_mark    = 1'b1;
        mark_style = m2h_pkg::STYLE_BOLD;
        unique case (char_in)
            m2h_pkg::CHAR_BOLD:      mark_style = m2h_pkg::STYLE_BOLD;
            m2h_pkg::CHAR_ITALIC:    mark_style = m2h_pkg::STYLE_ITALIC;
            m2h_pkg::CHAR_UNDERLINE: mark_style = m2h_pkg::STYLE_UNDERLINE;
            m2h_pkg::CHAR_CODE:      mark_style = m2h_pkg::STYLE_CODE;
            default:                 is_mark    = 1'b0;
        endcase
    end

    // Decision for the current byte: state update and the bytes it causes.
    always_comb
    begin
        cnt_next       = cnt_reg;
        flags_next     = flags_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        is_tag         = 1'b0;
        tag_close      = 1'b0;
        nl_shift       = '0;
        expansion.data = '0;
        expansion.len  = '0;
        expansion.err  = m2h_pkg::ERR_NONE;

        if (halted_reg) begin
            expansion.len = '0;
        end else if (is_mark) begin
            if (flags_reg[m2h_pkg::STYLE_CODE] && mark_style != m2h_pkg::STYLE_CODE) begin
                expansion.len = '0;
            end else if (cnt_reg >= CNT_W'(m2h_pkg::STACK_DEPTH)) begin
                expansion.len = LEN_W'(1);
                expansion.err = m2h_pkg::ERR_OVERFLOW;
                halted_next   = 1'b1;
            end else if (cnt_reg != '0 && top_style == mark_style) begin
                cnt_next               = cnt_m1;
                flags_next[mark_style] = 1'b0;
                is_tag                 = 1'b1;
                tag_close              = 1'b1;
            end else if (flags_reg[mark_style]) begin
                expansion.len = LEN_W'(1);
                expansion.err = m2h_pkg::ERR_ORDER;
                halted_next   = 1'b1;
            end else begin
                cnt_next               = cnt_reg + CNT_W'(1);
                flags_next[mark_style] = 1'b1;
                push                   = 1'b1;
                is_tag                 = 1'b1;
            end
        end else begin
            case (char_in)
                m2h_pkg::CHAR_QUOTE:
                begin
                    expansion.data = DAT_W'({";", "t", "o", "u", "q", "&"});
                    expansion.len  = LEN_W'(6);
                end
                m2h_pkg::CHAR_AMP:
                begin
                    expansion.data = DAT_W'({";", "p", "m", "a", "&"});
                    expansion.len  = LEN_W'(5);
                end
                m2h_pkg::CHAR_APOS:
                begin
                    expansion.data = DAT_W'({";", "s", "o", "p", "a", "&"});
                    expansion.len  = LEN_W'(6);
                end
                m2h_pkg::CHAR_LT:
                begin
                    expansion.data = DAT_W'({";", "t", "l", "&"});
                    expansion.len  = LEN_W'(4);
                end
                m2h_pkg::CHAR_GT:
                begin
                    expansion.data = DAT_W'({";", "t", "g", "&"});
                    expansion.len  = LEN_W'(4);
                end
                default:
                begin
                    expansion.data = DAT_W'(char_in);
                    expansion.len  = LEN_W'(1);
                end
            endcase
        end

        if (is_tag) begin
            expansion.data = m2h_pkg::tag_text(mark_style, tag_close);
            expansion.len  = m2h_pkg::tag_len(mark_style, tag_close);
            if (newline_after_tag) begin
                nl_shift = {expansion.len[2:0], 3'b000};
                expansion.data[nl_shift +: 8] = m2h_pkg::CHAR_NEWLINE;
                expansion.len = expansion.len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            flags_reg  <= '0;
            halted_reg <= 1'b0;
        end else if (fire) begin
            cnt_reg    <= cnt_next;
            flags_reg  <= flags_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push)
            stack_mem[cnt_reg[IDX_W-1:0]] <= mark_style;
    end

    `M2H_ASSERT_NEVER(a_cnt_in_range, cnt_reg > CNT_W'(m2h_pkg::STACK_DEPTH),
        "style stack count beyond depth")
    `M2H_ASSERT(a_flags_match_cnt, ($countones(flags_reg) == int'(cnt_reg)),
        "open-style flags disagree with stack count")
    `M2H_ASSERT(a_halt_sticky, halted_reg |=> halted_reg,
        "halted flag cleared without reset")

endmodule

/* design/m2h_out_buf.sv */
// ============================================================================
// Markup-to-HTML output buffer
// Holds one expansion and sends it out one byte per transaction.
// ============================================================================
`timescale 1ns / 1ps
`include "markup_to_html_stream_macros.svh"

module m2h_out_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,       // take a new expansion this cycle
    input  m2h_pkg::exp_t expansion,
    output logic          can_load,   // buffer is empty or drains its last byte now
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,    // out_byte
    output logic          m_tlast,    // last_of_run
    output logic [1:0]    m_tuser     // error_code
);

    localparam int LEN_W = m2h_pkg::EXP_LEN_W;
    localparam int DAT_W = m2h_pkg::EXP_DATA_W;

    logic [DAT_W-1:0] data_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [1:0]       err_reg;
    logic             send;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == LEN_W'(1));
    assign m_tdata  = data_reg[7:0];
    assign m_tuser  = err_reg;
    assign send     = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (send && m_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= expansion.len;
        end else if (send) begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= expansion.data;
            err_reg  <= expansion.err;
        end else if (send) begin
            data_reg <= data_reg >> 8;
        end
    end

    `M2H_ASSERT_NEVER(a_cnt_bound, cnt_reg > LEN_W'(m2h_pkg::MAX_RESULTS),
        "output buffer holds more bytes than an expansion can have")
    `M2H_ASSERT(a_err_single, (m_tvalid && err_reg != m2h_pkg::ERR_NONE) |-> (m_tlast && m_tdata == 8'h00),
        "error result is not a single zero byte")
    `M2H_ASSERT_NEVER(a_load_busy, load && !can_load,
        "expansion loaded over bytes not yet sent")

endmodule

/* design/markup_to_html_stream.sv */
// ============================================================================
// Markup-to-HTML stream converter
// Turns a text byte stream with style marks into an HTML byte stream.
// ============================================================================
`timescale 1ns / 1ps

// Each accepted byte on the slave side is held in an input register,
// decoded against the open-style stack and loaded as a whole expansion
// of zero to eight bytes into the output buffer, which then sends one byte per
// master-side transaction, with tlast on the last byte caused by that input.
// The output buffer is the rate limit: a byte holds the buffer until all of
// its results are sent (one for a plain byte, four to six for an entity, three
// to eight for a tag), and a byte that causes nothing (a mark swallowed inside
// code, or any byte after an error) does not hold it. The input side therefore
// runs at one transaction per cycle on plain text while the master side is
// ready. The marks '#', '~', '_' and backtick toggle bold, italic, underline
// and code. An order or overflow error gives one zero byte with the error
// code in tuser and tlast set, after which all input is accepted and dropped
// until reset. The newline_after_tag register (reset value 1) is written
// through the cfg channel, which is always ready; write it only while the
// block is idle.
module markup_to_html_stream
(
    input  logic       clk,
    input  logic       rst_n,

    // Configuration write channel: bit 0 is newline_after_tag.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    // Source text bytes.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // char_in

    // HTML bytes.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,    // last_of_run
    output logic [1:0] m_tuser     // error_code
);

    logic          nl_reg;
    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          can_load;
    logic          fire;
    m2h_pkg::exp_t expansion;

    // The configuration register is written on any valid beat, so the
    // channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nl_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            nl_reg <= cfg_data;
    end

    // The held byte is decoded and moves into the output buffer as soon as
    // the buffer is empty or is sending its last byte in this cycle.
    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_char_reg <= s_tdata;
    end

    m2h_style_ctrl u_style_ctrl
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .char_in           (in_char_reg),
        .newline_after_tag (nl_reg),
        .expansion         (expansion)
    );

    m2h_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .expansion (expansion),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

/* dv/testbench.sv */
// ============================================================================
// Markup-to-HTML stream converter testbench
// Sends directed and random text bytes into the converter and checks every
// HTML byte, its tlast and its error code against a predictor of the
// open-style stack. The sender works in bursts, the receiver stalls on its own
// pattern, and the newline-after-tag register is changed between phases.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    // Each emitted HTML byte, as the master side should present it.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } html_beat_t;

    // One row of the directed table. Where typed is set, html is the exact
    // expected output; otherwise the predictor supplies it.
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        string      html;
    } stim_row_t;

    localparam int DIRECTED_ROWS    = 24;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int RANDOM_PHASES    = 3;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HALTED_NOISE     = 20;

    // The directed table runs with newline_after_tag at its reset value of 1.
    // It walks every entity, every style in and out, marks swallowed inside
    // code (including one whose style is open lower down), and the byte
    // extremes.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{m2h_pkg::CHAR_BOLD,      1'b1, "<b>\n"},
        '{8'h61,                   1'b0, ""},
        '{m2h_pkg::CHAR_BOLD,      1'b1, "</b>\n"},
        '{m2h_pkg::CHAR_QUOTE,     1'b1, "&quot;"},
        '{m2h_pkg::CHAR_AMP,       1'b1, "&amp;"},
        '{m2h_pkg::CHAR_APOS,      1'b1, "&apos;"},
        '{m2h_pkg::CHAR_LT,        1'b1, "&lt;"},
        '{m2h_pkg::CHAR_GT,        1'b1, "&gt;"},
        '{8'h00,                   1'b0, ""},
        '{8'hFF,                   1'b0, ""},
        '{m2h_pkg::CHAR_NEWLINE,   1'b0, ""},
        '{m2h_pkg::CHAR_ITALIC,    1'b1, "<i>\n"},
        '{m2h_pkg::CHAR_UNDERLINE, 1'b1, "<u>\n"},
        '{m2h_pkg::CHAR_CODE,      1'b1, "<code>\n"},
        '{m2h_pkg::CHAR_BOLD,      1'b1, ""},
        '{m2h_pkg::CHAR_ITALIC,    1'b1, ""},
        '{m2h_pkg::CHAR_GT,        1'b1, "&gt;"},
        '{m2h_pkg::CHAR_CODE,      1'b1, "</code>\n"},
        '{m2h_pkg::CHAR_UNDERLINE, 1'b1, "</u>\n"},
        '{m2h_pkg::CHAR_BOLD,      1'b1, "<b>\n"},
        '{m2h_pkg::CHAR_BOLD,      1'b1, "</b>\n"},
        '{m2h_pkg::CHAR_ITALIC,    1'b1, "</i>\n"},
        '{8'h80,                   1'b0, ""},
        '{8'h7F,                   1'b0, ""}
    };

    // Every input of the converter starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    // Predictor state: the open-style stack, a mask of open styles, the halt
    // flag raised by the first error, and the newline-after-tag setting.
    m2h_pkg::style_t open_stack [m2h_pkg::STACK_DEPTH];
    int     open_depth       = 0;
    logic [3:0] open_mask    = 4'b0000;
    bit     converter_halted = 1'b0;
    bit     tag_newline      = 1'b1;

    // HTML bytes still owed by the converter, oldest first.
    html_beat_t html_expect_q [$];

    int mismatch_count = 0;
    int burst_left     = 1;
    bit long_hold_req  = 1'b0;

    markup_to_html_stream dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic bit decode_mark(input logic [7:0] c, output m2h_pkg::style_t s);
        s = m2h_pkg::STYLE_BOLD;
        case (c)
            m2h_pkg::CHAR_BOLD:      s = m2h_pkg::STYLE_BOLD;
            m2h_pkg::CHAR_ITALIC:    s = m2h_pkg::STYLE_ITALIC;
            m2h_pkg::CHAR_UNDERLINE: s = m2h_pkg::STYLE_UNDERLINE;
            m2h_pkg::CHAR_CODE:      s = m2h_pkg::STYLE_CODE;
            default:                 return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [7:0] style_mark_byte(input m2h_pkg::style_t s);
        case (s)
            m2h_pkg::STYLE_BOLD:      return m2h_pkg::CHAR_BOLD;
            m2h_pkg::STYLE_ITALIC:    return m2h_pkg::CHAR_ITALIC;
            m2h_pkg::STYLE_UNDERLINE: return m2h_pkg::CHAR_UNDERLINE;
            default:                  return m2h_pkg::CHAR_CODE;
        endcase
    endfunction

    function automatic string tag_name(input m2h_pkg::style_t s);
        case (s)
            m2h_pkg::STYLE_BOLD:      return "b";
            m2h_pkg::STYLE_ITALIC:    return "i";
            m2h_pkg::STYLE_UNDERLINE: return "u";
            default:                  return "code";
        endcase
    endfunction

    function automatic string entity_of(input logic [7:0] c);
        case (c)
            m2h_pkg::CHAR_QUOTE: return "&quot;";
            m2h_pkg::CHAR_AMP:   return "&amp;";
            m2h_pkg::CHAR_APOS:  return "&apos;";
            m2h_pkg::CHAR_LT:    return "&lt;";
            m2h_pkg::CHAR_GT:    return "&gt;";
            default:             return "";
        endcase
    endfunction

    // Spells a string out as HTML bytes, tlast on the final one.
    function automatic void text_to_beats(input string text, ref html_beat_t beats[$]);
        beats.delete();
        for (int i = 0; i < text.len(); i++)
            beats.push_back(html_beat_t'{text[i], (i == text.len() - 1),
                                         m2h_pkg::ERR_NONE});
    endfunction

    // Works out the HTML bytes caused by one source byte and updates the
    // style state the way the converter does.
    function automatic void render_char(input logic [7:0] c, ref html_beat_t beats[$]);
        m2h_pkg::style_t s;
        string           text;
        logic [1:0]      fault;
        beats.delete();
        fault = m2h_pkg::ERR_NONE;
        if (converter_halted)
            return;
        if (decode_mark(c, s))
        begin
            // Inside code only the backtick still acts.
            if (open_mask[m2h_pkg::STYLE_CODE] && s != m2h_pkg::STYLE_CODE)
                return;
            if (open_depth >= m2h_pkg::STACK_DEPTH)
            begin
                fault = m2h_pkg::ERR_OVERFLOW;
            end
            else if (open_depth > 0 && open_stack[open_depth - 1] == s)
            begin
                open_depth--;
                open_mask[s] = 1'b0;
                text = {"</", tag_name(s), ">"};
            end
            else if (open_mask[s])
            begin
                fault = m2h_pkg::ERR_ORDER;
            end
            else
            begin
                open_stack[open_depth] = s;
                open_depth++;
                open_mask[s] = 1'b1;
                text = {"<", tag_name(s), ">"};
            end
            if (fault != m2h_pkg::ERR_NONE)
            begin
                converter_halted = 1'b1;
                beats.push_back(html_beat_t'{8'h00, 1'b1, fault});
                return;
            end
            if (tag_newline)
                text = {text, "\n"};
            text_to_beats(text, beats);
        end
        else
        begin
            text = entity_of(c);
            if (text.len() == 0)
                beats.push_back(html_beat_t'{c, 1'b1, m2h_pkg::ERR_NONE});
            else
                text_to_beats(text, beats);
        end
    endfunction

    // A mark that neither raises an error nor fills the stack; a full stack
    // can only be left through an error, so that is saved for the end.
    function automatic bit mark_is_harmless(input m2h_pkg::style_t s);
        if (open_mask[m2h_pkg::STYLE_CODE] && s != m2h_pkg::STYLE_CODE)
            return 1'b1;
        if (open_depth >= m2h_pkg::STACK_DEPTH)
            return 1'b0;
        if (open_depth > 0 && open_stack[open_depth - 1] == s)
            return 1'b1;
        if (open_mask[s])
            return 1'b0;
        return (open_depth < m2h_pkg::STACK_DEPTH - 1);
    endfunction

    function automatic logic [7:0] pick_harmless_mark();
        m2h_pkg::style_t s;
        do
            s = m2h_pkg::style_t'($urandom_range(0, 3));
        while (!mark_is_harmless(s));
        return style_mark_byte(s);
    endfunction

    // Random source text: mostly well-formed nesting with random content, a
    // share of entity characters, and raw bytes over the whole range.
    function automatic logic [7:0] pick_char();
        int              roll;
        logic [7:0]      c;
        m2h_pkg::style_t s;
        roll = $urandom_range(0, 99);
        if (roll < 22)
            return pick_harmless_mark();
        if (roll < 37)
        begin
            case ($urandom_range(0, 4))
                0:       return m2h_pkg::CHAR_QUOTE;
                1:       return m2h_pkg::CHAR_AMP;
                2:       return m2h_pkg::CHAR_APOS;
                3:       return m2h_pkg::CHAR_LT;
                default: return m2h_pkg::CHAR_GT;
            endcase
        end
        c = 8'($urandom_range(0, 255));
        if (decode_mark(c, s) && !mark_is_harmless(s))
            c = pick_harmless_mark();
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Slave-side driver
    // ------------------------------------------------------------------------

    // Ends a burst now and then with a random gap of idle cycles.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Offers one source byte, waits for its transaction and books the HTML
    // bytes it must cause.
    task automatic offer_char(input logic [7:0] c, input bit typed, input string html);
        html_beat_t beats [$];
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        render_char(c, beats);
        if (typed)
            text_to_beats(html, beats);
        foreach (beats[i])
            html_expect_q.push_back(beats[i]);
        pace_sender();
    endtask

    // Stops sending and lets the converter run dry, including a byte that
    // causes no output but may still be in its pipeline.
    task automatic settle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (html_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_newline(input bit value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tag_newline = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Master-side receiver: switches among four stall patterns and, once
    // asked, holds off for a long stretch so that the converter fills up
    // and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int cycle;
        int mode;
        cycle = 0;
        mode  = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (cycle % 48 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cycle % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every master-side transaction is matched against the oldest
    // booked HTML byte, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        html_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (html_expect_q.size() == 0)
            begin
                $error("unexpected output transaction: data %02h last %0b user %0d",
                       m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = html_expect_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    $error("out_byte mismatch: expected %02h, got %02h", want.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_run mismatch: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.err)
                begin
                    $error("error_code mismatch: expected %0d, got %0d", want.err, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit phase_newline [RANDOM_PHASES];
        bit end_in_overflow;
        phase_newline = '{1'b0, 1'b1, 1'b0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 16);

        foreach (directed_rows[i])
            offer_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].html);

        // Random phases, each under its own newline setting. The long
        // receiver hold-off falls in the middle phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            program_newline(phase_newline[p]);
            if (p == 1)
                long_hold_req = 1'b1;
            repeat (RANDOM_PER_PHASE) offer_char(pick_char(), 1'b0, "");
        end

        // An error halts the converter until reset, so exactly one of the two
        // error kinds ends the run; the seed picks which. First every open
        // style is closed so that the lead-up is known.
        while (open_depth > 0)
            offer_char(style_mark_byte(open_stack[open_depth - 1]), 1'b0, "");
        end_in_overflow = 1'($urandom_range(0, 1));
        if (end_in_overflow)
        begin
            // All four styles open; a swallowed mark and text inside code,
            // then a backtick that would close code but meets a full stack.
            offer_char(m2h_pkg::CHAR_BOLD, 1'b0, "");
            offer_char(m2h_pkg::CHAR_ITALIC, 1'b0, "");
            offer_char(m2h_pkg::CHAR_UNDERLINE, 1'b0, "");
            offer_char(m2h_pkg::CHAR_CODE, 1'b0, "");
            offer_char(m2h_pkg::CHAR_BOLD, 1'b0, "");
            offer_char(8'h71, 1'b0, "");
            offer_char(m2h_pkg::CHAR_CODE, 1'b0, "");
        end
        else
        begin
            // Bold reopened while it sits below italic.
            offer_char(m2h_pkg::CHAR_BOLD, 1'b0, "");
            offer_char(m2h_pkg::CHAR_ITALIC, 1'b0, "");
            offer_char(m2h_pkg::CHAR_BOLD, 1'b0, "");
        end

        // Once halted, the converter drops everything.
        repeat (HALTED_NOISE) offer_char(8'($urandom_range(0, 255)), 1'b0, "");

        settle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin : watchdog
        #500000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/m2h_pkg.sv
design/m2h_style_ctrl.sv
design/m2h_out_buf.sv
design/markup_to_html_stream.sv
dv/testbench.sv
